FILE: src/ktr_pkg.sv
// ktr_pkg: shared types, constants and the count update function for the
// key reference-count event tracker. No dependencies.
package ktr_pkg;

  localparam logic [7:0] MOD_SCAN_LO = 8'hE0;
  localparam logic [7:0] MOD_SCAN_HI = 8'hE7;
  localparam logic [7:0] CNT_MAX     = 8'hFF;
  localparam logic [7:0] CNT_ZERO    = 8'h00;
  localparam logic [2:0] LAST_BIT    = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MASK,
    ST_FLUSH
  } ktr_state_t;

  typedef struct packed {
    logic       capture;
    logic       do_scan;
    logic       do_mask;
    logic       flush;
    logic [2:0] bit_idx;
  } ktr_cmd_t;

  typedef struct packed {
    logic can_move;
    logic pend_valid;
  } ktr_stat_t;

  typedef struct packed {
    logic       is_modifier;
    logic       went_down;
    logic [7:0] code;
    logic       last;
  } ktr_evt_t;

  typedef struct packed {
    logic [7:0] cnt;
    logic       rise;
    logic       fall;
  } ktr_bump_t;

  function automatic ktr_bump_t bump(input logic [7:0] old, input logic up);
    ktr_bump_t r;
    r.cnt = old;
    if (up && old != CNT_MAX) begin
      r.cnt = old + 8'd1;
    end
    if (!up && old != CNT_ZERO) begin
      r.cnt = old - 8'd1;
    end
    r.rise = (old == CNT_ZERO) && (r.cnt != CNT_ZERO);
    r.fall = (old != CNT_ZERO) && (r.cnt == CNT_ZERO);
    return r;
  endfunction

endpackage

FILE: src/ktr_key_if.sv
// ktr_key_if: valid/ready channel carrying one key transition request.
// No dependencies.
interface ktr_key_if;
  logic        valid;
  logic        ready;
  logic [15:0] key_code;
  logic        is_press;

  modport source (output valid, output key_code, output is_press, input ready);
  modport sink   (input valid, input key_code, input is_press, output ready);
endinterface

FILE: src/ktr_evt_if.sv
// ktr_evt_if: valid/ready channel carrying one key event request.
// No dependencies.
interface ktr_evt_if;
  logic       valid;
  logic       ready;
  logic       is_modifier;
  logic       went_down;
  logic [7:0] code;
  logic       last;

  modport source (output valid, output is_modifier, output went_down, output code,
                  output last, input ready);
  modport sink   (input valid, input is_modifier, input went_down, input code,
                  input last, output ready);
endinterface

FILE: src/key_refcount_event_tracker.sv
// Key reference-count event tracker: per-key saturating counts, 0<->1 events.
// Steps: accept, scancode step, eight mask steps, then a flush when an event
// is pending; the mask pass walks one modifier bit a cycle unless the event
// output is held off. A new item is accepted only after the last one ends.
// Reset: all counts read as zero at once (per-entry valid bits); no clear pass.
// Depends on ktr_pkg, ktr_key_if, ktr_evt_if, ktr_ctrl, ktr_dp.
module key_refcount_event_tracker
  import ktr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  ktr_key_if.sink  keys,
  ktr_evt_if.source events
);

  ktr_cmd_t  cmd;
  ktr_stat_t stat;
  ktr_evt_t  evt;
  logic      evt_valid;
  logic      keys_ready;

  ktr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .keys_valid (keys.valid),
    .keys_ready (keys_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ktr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .key_code  (keys.key_code),
    .is_press  (keys.is_press),
    .evt_ready (events.ready),
    .stat      (stat),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  assign keys.ready         = keys_ready;
  assign events.valid       = evt_valid;
  assign events.is_modifier = evt.is_modifier;
  assign events.went_down   = evt.went_down;
  assign events.code        = evt.code;
  assign events.last        = evt.last;

endmodule

FILE: src/ktr_ctrl.sv
// ktr_ctrl: sequencer stepping through scancode and the eight mask bits.
// Depends on ktr_pkg.
module ktr_ctrl
  import ktr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      keys_valid,
  output logic      keys_ready,
  input  ktr_stat_t stat,
  output ktr_cmd_t  cmd
);

  ktr_state_t state, state_next;
  logic [2:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= 3'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    keys_ready  = 1'b0;
    cmd         = '0;
    cmd.bit_idx = idx;
    case (state)
      ST_IDLE: begin
        keys_ready = 1'b1;
        if (keys_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.can_move) begin
          cmd.do_scan = 1'b1;
          idx_next    = 3'd0;
          state_next  = ST_MASK;
        end
      end
      ST_MASK: begin
        if (stat.can_move) begin
          cmd.do_mask = 1'b1;
          if (idx == LAST_BIT) begin
            state_next = ST_FLUSH;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = ST_IDLE;
        end else if (stat.can_move) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !stat.pend_valid)
    else $error("pending event left over in idle");

  a_mask_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_mask && idx == LAST_BIT) |=> state == ST_FLUSH)
    else $error("mask pass did not end in flush");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.capture, cmd.do_scan, cmd.do_mask, cmd.flush}) <= 1)
    else $error("more than one command at once");

endmodule

FILE: src/ktr_dp.sv
// ktr_dp: count stores, update logic, pending event and output register.
// Depends on ktr_pkg.
module ktr_dp
  import ktr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ktr_cmd_t    cmd,
  input  logic [15:0] key_code,
  input  logic        is_press,
  input  logic        evt_ready,
  output ktr_stat_t   stat,
  output logic        evt_valid,
  output ktr_evt_t    evt
);

  logic [7:0] mask_r;
  logic [7:0] scan_r;
  logic       up_r;
  logic [7:0] mem [256];
  logic       vld [256];
  logic [7:0] rd_data;
  logic       rd_vld;
  logic [7:0] modc [8];
  logic       p_valid;
  ktr_evt_t   p_evt;
  logic       o_valid;
  ktr_evt_t   o_evt;

  logic       scan_is_mod;
  logic       active;
  logic [7:0] old_cnt;
  ktr_evt_t   new_evt;
  ktr_bump_t  upd;
  logic       fire;
  logic       load_out;
  logic       can_move;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mask_r  <= key_code[15:8];
      scan_r  <= key_code[7:0];
      up_r    <= is_press;
      rd_data <= mem[key_code[7:0]];
      rd_vld  <= vld[key_code[7:0]];
    end
  end

  assign scan_is_mod = (scan_r >= MOD_SCAN_LO) && (scan_r <= MOD_SCAN_HI);

  always_comb begin
    active      = 1'b0;
    old_cnt     = CNT_ZERO;
    new_evt     = '0;
    if (cmd.do_scan) begin
      active = 1'b1;
      if (scan_is_mod) begin
        old_cnt             = modc[scan_r[2:0]];
        new_evt.is_modifier = 1'b1;
        new_evt.code        = {5'd0, scan_r[2:0]};
      end else begin
        old_cnt      = rd_vld ? rd_data : CNT_ZERO;
        new_evt.code = scan_r;
      end
    end else if (cmd.do_mask) begin
      active              = mask_r[cmd.bit_idx];
      old_cnt             = modc[cmd.bit_idx];
      new_evt.is_modifier = 1'b1;
      new_evt.code        = {5'd0, cmd.bit_idx};
    end
    upd               = bump(old_cnt, up_r);
    new_evt.went_down = upd.rise;
    fire              = active && (upd.rise || upd.fall);
  end

  assign can_move = !o_valid || evt_ready;
  assign load_out = (fire && p_valid) || cmd.flush;

  always_ff @(posedge clk) begin
    if (cmd.do_scan && !scan_is_mod) begin
      mem[scan_r] <= upd.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 256; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (cmd.do_scan && !scan_is_mod) begin
      vld[scan_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        modc[i] <= CNT_ZERO;
      end
    end else if (cmd.do_scan && scan_is_mod) begin
      modc[scan_r[2:0]] <= upd.cnt;
    end else if (cmd.do_mask && active) begin
      modc[cmd.bit_idx] <= upd.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (fire) begin
        p_valid <= 1'b1;
      end else if (cmd.flush) begin
        p_valid <= 1'b0;
      end
      if (load_out) begin
        o_valid <= 1'b1;
      end else if (evt_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      p_evt <= new_evt;
    end
    if (load_out) begin
      o_evt <= '{is_modifier: p_evt.is_modifier, went_down: p_evt.went_down,
                 code: p_evt.code, last: cmd.flush};
    end
  end

  assign stat.can_move   = can_move;
  assign stat.pend_valid = p_valid;
  assign evt_valid       = o_valid;
  assign evt             = o_evt;

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load_out |-> can_move)
    else $error("output register overwritten");

  a_flush_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> p_valid)
    else $error("flush without pending event");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> (o_valid && o_evt.last))
    else $error("flush did not present a final event");

endmodule

FILE: verif/ktr_checker.sv
// ktr_checker: watches the key and event channels of the key tracker, keeps its own
// per-key counts, predicts the event requests and compares them in order.
// Depends on ktr_pkg, ktr_key_if and ktr_evt_if.
module ktr_checker
  import ktr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ktr_key_if   keys,
  ktr_evt_if   events,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] scan_refs [256];
  logic [7:0] mod_refs [8];
  ktr_evt_t   expected_events [$];
  int         fails;
  int         queued;

  assign fail_count    = fails;
  assign pending_count = queued;

  // +1 on a rise from zero, -1 on a fall to zero, 0 otherwise
  function automatic int count_step(input logic [7:0] old, input logic up,
                                    output logic [7:0] nxt);
    nxt = old;
    if (up && old != CNT_MAX) begin
      nxt = old + 8'd1;
    end else if (!up && old != CNT_ZERO) begin
      nxt = old - 8'd1;
    end
    if (old == CNT_ZERO && nxt != CNT_ZERO) return 1;
    if (old != CNT_ZERO && nxt == CNT_ZERO) return -1;
    return 0;
  endfunction

  task automatic predict_events(input logic [15:0] key_code, input logic press);
    logic [7:0] scan;
    logic [7:0] mask;
    logic [7:0] nxt;
    int         dir;
    ktr_evt_t   batch [$];
    scan = key_code[7:0];
    mask = key_code[15:8];
    if (scan >= MOD_SCAN_LO && scan <= MOD_SCAN_HI) begin
      dir = count_step(mod_refs[scan[2:0]], press, nxt);
      mod_refs[scan[2:0]] = nxt;
      if (dir != 0) batch.push_back('{1'b1, dir > 0, {5'd0, scan[2:0]}, 1'b0});
    end else begin
      dir = count_step(scan_refs[scan], press, nxt);
      scan_refs[scan] = nxt;
      if (dir != 0) batch.push_back('{1'b0, dir > 0, scan, 1'b0});
    end
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        dir = count_step(mod_refs[i], press, nxt);
        mod_refs[i] = nxt;
        if (dir != 0) batch.push_back('{1'b1, dir > 0, 8'(i), 1'b0});
      end
    end
    for (int i = 0; i < batch.size(); i++) begin
      if (i == batch.size() - 1) batch[i].last = 1'b1;
      expected_events.push_back(batch[i]);
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_event();
    ktr_evt_t want;
    if (expected_events.size() == 0) begin
      $error("unexpected event request: is_modifier=%0d went_down=%0d code=0x%02h last=%0d",
             events.is_modifier, events.went_down, events.code, events.last);
      fails++;
    end else begin
      want = expected_events.pop_front();
      compare_field("is_modifier", want.is_modifier, events.is_modifier);
      compare_field("went_down", want.went_down, events.went_down);
      compare_field("code", want.code, events.code);
      compare_field("last", want.last, events.last);
    end
  endtask

  initial begin
    fails  = 0;
    queued = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      foreach (scan_refs[i]) scan_refs[i] = CNT_ZERO;
      foreach (mod_refs[i]) mod_refs[i] = CNT_ZERO;
      expected_events.delete();
    end else begin
      if (events.valid && events.ready) check_event();
      if (keys.valid && keys.ready) predict_events(keys.key_code, keys.is_press);
    end
    queued = expected_events.size();
  end

endmodule

FILE: verif/tb_top.sv
// tb_top: drives key transition requests into key_refcount_event_tracker with
// random gaps and event back-pressure; ktr_checker judges the event requests.
// Depends on ktr_pkg, ktr_key_if, ktr_evt_if, ktr_checker and the tracker.
module tb_top
  import ktr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_KEYS = 227;
  localparam int NUM_DIRECTED = 23;

  logic clk = 1'b0;
  logic rst;
  logic calm;
  int   chk_fails;
  int   chk_pending;

  ktr_key_if key_ch ();
  ktr_evt_if evt_ch ();

  key_refcount_event_tracker dut (
    .clk    (clk),
    .rst    (rst),
    .keys   (key_ch),
    .events (evt_ch)
  );

  ktr_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .keys          (key_ch),
    .events        (evt_ch),
    .fail_count    (chk_fails),
    .pending_count (chk_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    evt_ch.ready <= calm || $urandom_range(0, 99) >= 21;
  end

  // {press, key_code}
  logic [16:0] directed [NUM_DIRECTED] = '{
    {1'b1, 16'h0000}, {1'b1, 16'h0000}, {1'b0, 16'h0000}, {1'b0, 16'h0000},
    {1'b0, 16'h0000}, {1'b1, 16'hFFFF}, {1'b0, 16'hFFFF}, {1'b1, 16'h08E3},
    {1'b0, 16'h08E3}, {1'b1, 16'h00E0}, {1'b1, 16'h01E7}, {1'b0, 16'h00E0},
    {1'b0, 16'h01E7}, {1'b1, 16'h0204}, {1'b1, 16'h0004}, {1'b0, 16'h0204},
    {1'b0, 16'h0004}, {1'b1, 16'h8000}, {1'b0, 16'h8000}, {1'b1, 16'h5529},
    {1'b1, 16'hAA29}, {1'b0, 16'h5529}, {1'b0, 16'hAA29}
  };

  task automatic send_key(input logic [15:0] key_code, input logic press);
    while (!calm && $urandom_range(0, 99) < 21) begin
      key_ch.valid <= 1'b0;
      @(posedge clk);
    end
    key_ch.valid    <= 1'b1;
    key_ch.key_code <= key_code;
    key_ch.is_press <= press;
    do @(posedge clk); while (!key_ch.ready);
  endtask

  // small pools of scancodes and masks so counts keep crossing zero
  function automatic logic [15:0] random_key();
    logic [7:0] scan;
    logic [7:0] mask;
    case ($urandom_range(0, 3))
      0: scan = 8'h04 + 8'($urandom_range(0, 3));
      1: scan = MOD_SCAN_LO + 8'($urandom_range(0, 7));
      2: scan = 8'h00;
      default: scan = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0, 1: mask = 8'h00;
      2: mask = 8'h01 << $urandom_range(0, 7);
      default: mask = 8'($urandom);
    endcase
    return {mask, scan};
  endfunction

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [15:0] held [$];
    logic [15:0] key_code;
    int          pick;
    int          idx;
    int          waited;
    rst             <= 1'b1;
    calm            <= 1'b0;
    key_ch.valid    <= 1'b0;
    key_ch.key_code <= '0;
    key_ch.is_press <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_key(directed[i][15:0], directed[i][16]);

    for (int n = 0; n < RANDOM_KEYS; n++) begin
      calm <= (n >= 100 && n < 160);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_key(16'($urandom), 1'($urandom));
      end else if (held.size() > 0 && (pick < 50 || held.size() >= 6)) begin
        idx = $urandom_range(0, held.size() - 1);
        key_code = held[idx];
        held.delete(idx);
        send_key(key_code, 1'b0);
      end else begin
        key_code = random_key();
        held.push_back(key_code);
        send_key(key_code, 1'b1);
      end
    end
    key_ch.valid <= 1'b0;
    calm <= 1'b0;

    @(posedge clk);
    waited = 0;
    while (chk_pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (chk_pending != 0) $error("%0d expected event requests never arrived", chk_pending);

    if (chk_fails == 0 && chk_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
